### rtl/core/mwsp_pkg.sv
package mwsp_pkg;

	localparam int WHEEL_COUNT = 4;
	localparam int WHEEL_W     = $clog2(WHEEL_COUNT);
	localparam int STICK_W     = 11;
	localparam int WORD_W      = 16;
	localparam int GAIN_W      = 8;
	localparam int LIMIT_W     = 15;
	localparam int BAND_W      = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 15;

	// Divider: the magnitude of a 16-bit signed value needs 17 bits, one bit per step.
	localparam int DIV_STEPS   = WORD_W + 1;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int QUOT_W      = WORD_W + 2;

	// Working width of the drive sum: 25-bit and 26-bit products plus an 18-bit quotient.
	localparam int WIDE_W      = 28;
	localparam int MIX_W       = 20;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 8'd50;
	localparam logic [GAIN_W-1:0]  INT_DIV_RST     = 8'd5;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 8'd3;
	localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST   = 15'd25000;
	localparam logic [GAIN_W-1:0]  ROT_DIV_RST     = 8'd5;
	localparam logic [BAND_W-1:0]  ROT_BAND_RST    = 10'd10;
	localparam logic [GAIN_W-1:0]  YAW_DIV_RST     = 8'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INT_DIV    = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_OUT_LIMIT  = 3'd3,
		REG_ROT_DIV    = 3'd4,
		REG_ROT_BAND   = 3'd5,
		REG_YAW_DIV    = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ROT_FIX,
		OP_YAW_ADD,
		OP_TGT,
		OP_ERR,
		OP_SUM,
		OP_MUL,
		OP_ACC,
		OP_PUBLISH
	} dp_op_t;

	typedef enum logic [1:0] {
		DIV_ROT,
		DIV_YAW,
		DIV_SUM
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT_DIV,
		ST_ROT_WAIT,
		ST_YAW_DIV,
		ST_YAW_WAIT,
		ST_TGT,
		ST_ERR,
		ST_SUM,
		ST_INT_DIV,
		ST_INT_WAIT,
		ST_PUBLISH
	} ctl_state_t;

	typedef struct packed {
		logic signed [STICK_W-1:0] strafe_stick;
		logic signed [STICK_W-1:0] forward_stick;
		logic signed [STICK_W-1:0] rotate_stick;
		logic signed [WORD_W-1:0]  yaw_correction;
		logic signed [WORD_W-1:0]  speed_front_a;
		logic signed [WORD_W-1:0]  speed_front_b;
		logic signed [WORD_W-1:0]  speed_rear_a;
		logic signed [WORD_W-1:0]  speed_rear_b;
	} tick_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] drive_front_a;
		logic signed [WORD_W-1:0] drive_front_b;
		logic signed [WORD_W-1:0] drive_rear_a;
		logic signed [WORD_W-1:0] drive_rear_b;
	} drive_item_t;

	typedef struct packed {
		dp_op_t             op;
		logic               div_start;
		div_sel_t           div_sel;
		logic [WHEEL_W-1:0] wheel;
	} ctl_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_status_t;

	function automatic logic signed [WORD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > 28'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -28'sd32768) begin
			r = -16'sh8000;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/mwsp_if.sv
interface mwsp_tick_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mwsp_pkg::STICK_W-1:0]  strafe_stick;
	logic signed [mwsp_pkg::STICK_W-1:0]  forward_stick;
	logic signed [mwsp_pkg::STICK_W-1:0]  rotate_stick;
	logic signed [mwsp_pkg::WORD_W-1:0]   yaw_correction;
	logic signed [mwsp_pkg::WORD_W-1:0]   speed_front_a;
	logic signed [mwsp_pkg::WORD_W-1:0]   speed_front_b;
	logic signed [mwsp_pkg::WORD_W-1:0]   speed_rear_a;
	logic signed [mwsp_pkg::WORD_W-1:0]   speed_rear_b;

	modport source (
		output valid, strafe_stick, forward_stick, rotate_stick, yaw_correction,
		       speed_front_a, speed_front_b, speed_rear_a, speed_rear_b,
		input  ready
	);
	modport sink (
		input  valid, strafe_stick, forward_stick, rotate_stick, yaw_correction,
		       speed_front_a, speed_front_b, speed_rear_a, speed_rear_b,
		output ready
	);
endinterface

interface mwsp_drive_if;
	logic                               valid;
	logic                               ready;
	logic signed [mwsp_pkg::WORD_W-1:0] drive_front_a;
	logic signed [mwsp_pkg::WORD_W-1:0] drive_front_b;
	logic signed [mwsp_pkg::WORD_W-1:0] drive_rear_a;
	logic signed [mwsp_pkg::WORD_W-1:0] drive_rear_b;

	modport source (
		output valid, drive_front_a, drive_front_b, drive_rear_a, drive_rear_b,
		input  ready
	);
	modport sink (
		input  valid, drive_front_a, drive_front_b, drive_rear_a, drive_rear_b,
		output ready
	);
endinterface

interface mwsp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mwsp_pkg::CFG_IDX_W-1:0]    index;
	logic [mwsp_pkg::CFG_DATA_W-1:0]   data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

### rtl/core/mwsp_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module mwsp_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [mwsp_pkg::WORD_W-1:0]    dividend,
	input  logic [mwsp_pkg::GAIN_W-1:0]           divisor,
	output logic signed [mwsp_pkg::QUOT_W-1:0]    quotient,
	output logic                                  done
);

	logic [mwsp_pkg::DIV_STEPS-1:0] quo_q;
	logic [mwsp_pkg::GAIN_W-1:0]    rem_q;
	logic [mwsp_pkg::GAIN_W-1:0]    dvs_q;
	logic [mwsp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           neg_q;
	logic                           done_q;

	logic signed [mwsp_pkg::DIV_STEPS-1:0] num_ext;
	logic [mwsp_pkg::DIV_STEPS-1:0]        num_mag;
	logic [mwsp_pkg::GAIN_W+1:0]           trial;
	logic signed [mwsp_pkg::QUOT_W-1:0]    quo_ext;

	always_comb begin
		num_ext = mwsp_pkg::DIV_STEPS'(dividend);
		num_mag = num_ext[mwsp_pkg::DIV_STEPS-1] ? unsigned'(-num_ext) : unsigned'(num_ext);
		trial   = {1'b0, rem_q, quo_q[mwsp_pkg::DIV_STEPS-1]} - {2'b00, dvs_q};
		quo_ext = signed'({1'b0, quo_q});
		quotient = neg_q ? -quo_ext : quo_ext;
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mwsp_pkg::DIV_CNT_W'(mwsp_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num_mag;
			rem_q <= '0;
			neg_q <= dividend[mwsp_pkg::WORD_W-1];
			dvs_q <= (divisor == '0) ? mwsp_pkg::GAIN_W'(1) : divisor;
		end else if (busy_q) begin
			if (!trial[mwsp_pkg::GAIN_W+1]) begin
				rem_q <= trial[mwsp_pkg::GAIN_W-1:0];
				quo_q <= {quo_q[mwsp_pkg::DIV_STEPS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[mwsp_pkg::GAIN_W-2:0], quo_q[mwsp_pkg::DIV_STEPS-1]};
				quo_q <= {quo_q[mwsp_pkg::DIV_STEPS-2:0], 1'b0};
			end
		end
	end

endmodule

### rtl/core/mwsp_datapath.sv
// Operand registers, wheel state, configuration registers and the shared divider.
module mwsp_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mwsp_pkg::ctl_cmd_t                   cmd,
	output mwsp_pkg::dp_status_t                 status,
	input  mwsp_pkg::tick_item_t                 item_in,
	output mwsp_pkg::drive_item_t                item_out,
	input  logic                                 cfg_we,
	input  logic [mwsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mwsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int W  = mwsp_pkg::WORD_W;
	localparam int WW = mwsp_pkg::WIDE_W;
	localparam int MW = mwsp_pkg::MIX_W;
	localparam int QW = mwsp_pkg::QUOT_W;
	localparam int PW = mwsp_pkg::GAIN_W + 1 + W;
	localparam int DW = mwsp_pkg::GAIN_W + 2 + W;

	logic [mwsp_pkg::GAIN_W-1:0]  prop_gain_q;
	logic [mwsp_pkg::GAIN_W-1:0]  int_div_q;
	logic [mwsp_pkg::GAIN_W-1:0]  deriv_gain_q;
	logic [mwsp_pkg::LIMIT_W-1:0] out_limit_q;
	logic [mwsp_pkg::GAIN_W-1:0]  rot_div_q;
	logic [mwsp_pkg::BAND_W-1:0]  rot_band_q;
	logic [mwsp_pkg::GAIN_W-1:0]  yaw_div_q;

	logic signed [mwsp_pkg::STICK_W-1:0] strafe_q;
	logic signed [mwsp_pkg::STICK_W-1:0] fwd_q;
	logic signed [mwsp_pkg::STICK_W-1:0] rot_stick_q;
	logic signed [W-1:0]                 yaw_q;
	logic signed [W-1:0]                 spd_q [mwsp_pkg::WHEEL_COUNT];

	logic signed [QW-1:0] rot_q;
	logic signed [W-1:0]  tgt_q;
	logic signed [W-1:0]  err_q;
	logic signed [W-1:0]  sum_q;
	logic signed [W:0]    dif_q;
	logic signed [PW-1:0] pterm_q;
	logic signed [DW-1:0] dterm_q;
	logic signed [W-1:0]  drv_q [mwsp_pkg::WHEEL_COUNT];
	logic signed [W-1:0]  out_q [mwsp_pkg::WHEEL_COUNT];

	logic signed [W-1:0]  err_sum_q [mwsp_pkg::WHEEL_COUNT];
	logic signed [W-1:0]  prior_q [mwsp_pkg::WHEEL_COUNT];
	logic                 first_q;

	logic signed [W-1:0]          div_num;
	logic [mwsp_pkg::GAIN_W-1:0]  div_den;
	logic signed [QW-1:0]         div_quot;
	logic                         div_done;

	logic [QW-1:0]        quot_mag;
	logic signed [MW-1:0] f_ext, s_ext, mix;
	logic signed [W-1:0]  mix_sat;
	logic signed [W:0]    tgt_minus;
	logic signed [W:0]    sum_plus;
	logic signed [W:0]    dif_next;
	logic signed [WW-1:0] drv_wide;
	logic signed [W-1:0]  drv_sat;
	logic signed [W-1:0]  drv_lim;
	logic signed [W-1:0]  limit_s;

	mwsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quot),
		.done     (div_done)
	);

	assign status.div_done = div_done;

	always_comb begin
		unique case (cmd.div_sel)
			mwsp_pkg::DIV_ROT: begin
				div_num = W'(rot_stick_q);
				div_den = rot_div_q;
			end
			mwsp_pkg::DIV_YAW: begin
				div_num = yaw_q;
				div_den = yaw_div_q;
			end
			mwsp_pkg::DIV_SUM: begin
				div_num = sum_q;
				div_den = int_div_q;
			end
			default: begin
				div_num = sum_q;
				div_den = int_div_q;
			end
		endcase

		quot_mag = div_quot[QW-1] ? unsigned'(-div_quot) : unsigned'(div_quot);

		// Wheels one and two take the forward stick negated, two and three the strafe.
		f_ext = MW'(fwd_q);
		s_ext = MW'(strafe_q);
		if (cmd.wheel == mwsp_pkg::WHEEL_W'(1) || cmd.wheel == mwsp_pkg::WHEEL_W'(2)) begin
			f_ext = -f_ext;
		end
		if (cmd.wheel == mwsp_pkg::WHEEL_W'(2) || cmd.wheel == mwsp_pkg::WHEEL_W'(3)) begin
			s_ext = -s_ext;
		end
		mix     = f_ext + s_ext + MW'(rot_q);
		mix_sat = mwsp_pkg::sat16(WW'(mix));

		tgt_minus = (W+1)'(tgt_q) - (W+1)'(spd_q[cmd.wheel]);
		sum_plus  = (W+1)'(err_sum_q[cmd.wheel]) + (W+1)'(err_q);
		dif_next  = (W+1)'(err_q) - (W+1)'(prior_q[cmd.wheel]);

		drv_wide = WW'(pterm_q) + WW'(dterm_q) + WW'(div_quot);
		drv_sat  = mwsp_pkg::sat16(drv_wide);
		limit_s  = signed'({1'b0, out_limit_q});
		drv_lim  = (drv_sat > limit_s) ? limit_s : drv_sat;
	end

	assign item_out.drive_front_a = out_q[0];
	assign item_out.drive_front_b = out_q[1];
	assign item_out.drive_rear_a  = out_q[2];
	assign item_out.drive_rear_b  = out_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= mwsp_pkg::PROP_GAIN_RST;
			int_div_q    <= mwsp_pkg::INT_DIV_RST;
			deriv_gain_q <= mwsp_pkg::DERIV_GAIN_RST;
			out_limit_q  <= mwsp_pkg::OUT_LIMIT_RST;
			rot_div_q    <= mwsp_pkg::ROT_DIV_RST;
			rot_band_q   <= mwsp_pkg::ROT_BAND_RST;
			yaw_div_q    <= mwsp_pkg::YAW_DIV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mwsp_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data[mwsp_pkg::GAIN_W-1:0];
				mwsp_pkg::REG_INT_DIV:    int_div_q    <= cfg_data[mwsp_pkg::GAIN_W-1:0];
				mwsp_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data[mwsp_pkg::GAIN_W-1:0];
				mwsp_pkg::REG_OUT_LIMIT:  out_limit_q  <= cfg_data[mwsp_pkg::LIMIT_W-1:0];
				mwsp_pkg::REG_ROT_DIV:    rot_div_q    <= cfg_data[mwsp_pkg::GAIN_W-1:0];
				mwsp_pkg::REG_ROT_BAND:   rot_band_q   <= cfg_data[mwsp_pkg::BAND_W-1:0];
				mwsp_pkg::REG_YAW_DIV:    yaw_div_q    <= cfg_data[mwsp_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mwsp_pkg::WHEEL_COUNT; i++) begin
				err_sum_q[i] <= '0;
				prior_q[i]   <= '0;
			end
			first_q <= 1'b1;
		end else begin
			if (cmd.op == mwsp_pkg::OP_ACC) begin
				err_sum_q[cmd.wheel] <= sum_q;
				prior_q[cmd.wheel]   <= err_q;
			end
			if (cmd.op == mwsp_pkg::OP_PUBLISH) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mwsp_pkg::OP_LOAD: begin
				strafe_q    <= item_in.strafe_stick;
				fwd_q       <= item_in.forward_stick;
				rot_stick_q <= item_in.rotate_stick;
				yaw_q       <= item_in.yaw_correction;
				spd_q[0]    <= item_in.speed_front_a;
				spd_q[1]    <= item_in.speed_front_b;
				spd_q[2]    <= item_in.speed_rear_a;
				spd_q[3]    <= item_in.speed_rear_b;
			end
			mwsp_pkg::OP_ROT_FIX: begin
				rot_q <= (quot_mag < QW'(rot_band_q)) ? '0 : div_quot;
			end
			mwsp_pkg::OP_YAW_ADD: begin
				rot_q <= rot_q + div_quot;
			end
			mwsp_pkg::OP_TGT: begin
				tgt_q <= mix_sat;
			end
			mwsp_pkg::OP_ERR: begin
				err_q <= mwsp_pkg::sat16(WW'(tgt_minus));
			end
			mwsp_pkg::OP_SUM: begin
				sum_q <= mwsp_pkg::sat16(WW'(sum_plus));
				dif_q <= dif_next;
			end
			mwsp_pkg::OP_MUL: begin
				pterm_q <= signed'({1'b0, prop_gain_q}) * err_q;
				// The product must stay signed, so it is not mixed with an unsized zero.
				if (first_q) begin
					dterm_q <= '0;
				end else begin
					dterm_q <= signed'({1'b0, deriv_gain_q}) * dif_q;
				end
			end
			mwsp_pkg::OP_ACC: begin
				drv_q[cmd.wheel] <= drv_lim;
			end
			mwsp_pkg::OP_PUBLISH: begin
				for (int i = 0; i < mwsp_pkg::WHEEL_COUNT; i++) begin
					out_q[i] <= drv_q[i];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/mwsp_ctrl.sv
// Sequencer: one tick at a time, wheels visited in order.
module mwsp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mwsp_pkg::ctl_cmd_t   cmd,
	input  mwsp_pkg::dp_status_t status
);

	mwsp_pkg::ctl_state_t state_q, state_d;
	logic [mwsp_pkg::WHEEL_W-1:0] wheel_q, wheel_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mwsp_pkg::ST_IDLE;
			wheel_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			wheel_q     <= wheel_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		wheel_d       = wheel_q;
		out_valid_d   = out_valid_q && !out_ready;
		in_ready      = 1'b0;
		cmd.op        = mwsp_pkg::OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = mwsp_pkg::DIV_SUM;
		cmd.wheel     = wheel_q;

		unique case (state_q)
			mwsp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = mwsp_pkg::OP_LOAD;
					wheel_d = '0;
					state_d = mwsp_pkg::ST_ROT_DIV;
				end
			end
			mwsp_pkg::ST_ROT_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = mwsp_pkg::DIV_ROT;
				state_d       = mwsp_pkg::ST_ROT_WAIT;
			end
			mwsp_pkg::ST_ROT_WAIT: begin
				if (status.div_done) begin
					cmd.op  = mwsp_pkg::OP_ROT_FIX;
					state_d = mwsp_pkg::ST_YAW_DIV;
				end
			end
			mwsp_pkg::ST_YAW_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = mwsp_pkg::DIV_YAW;
				state_d       = mwsp_pkg::ST_YAW_WAIT;
			end
			mwsp_pkg::ST_YAW_WAIT: begin
				if (status.div_done) begin
					cmd.op  = mwsp_pkg::OP_YAW_ADD;
					state_d = mwsp_pkg::ST_TGT;
				end
			end
			mwsp_pkg::ST_TGT: begin
				cmd.op  = mwsp_pkg::OP_TGT;
				state_d = mwsp_pkg::ST_ERR;
			end
			mwsp_pkg::ST_ERR: begin
				cmd.op  = mwsp_pkg::OP_ERR;
				state_d = mwsp_pkg::ST_SUM;
			end
			mwsp_pkg::ST_SUM: begin
				cmd.op  = mwsp_pkg::OP_SUM;
				state_d = mwsp_pkg::ST_INT_DIV;
			end
			mwsp_pkg::ST_INT_DIV: begin
				cmd.op        = mwsp_pkg::OP_MUL;
				cmd.div_start = 1'b1;
				cmd.div_sel   = mwsp_pkg::DIV_SUM;
				state_d       = mwsp_pkg::ST_INT_WAIT;
			end
			mwsp_pkg::ST_INT_WAIT: begin
				if (status.div_done) begin
					cmd.op  = mwsp_pkg::OP_ACC;
					wheel_d = wheel_q + 1'b1;
					if (wheel_q == mwsp_pkg::WHEEL_W'(mwsp_pkg::WHEEL_COUNT - 1)) begin
						state_d = mwsp_pkg::ST_PUBLISH;
					end else begin
						state_d = mwsp_pkg::ST_TGT;
					end
				end
			end
			mwsp_pkg::ST_PUBLISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = mwsp_pkg::OP_PUBLISH;
					out_valid_d = 1'b1;
					state_d     = mwsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mwsp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/mecanum_wheel_speed_pid_core.sv
// Channel  Role   Carries
// -------  -----  -------------------------------------------------------------
// tick     sink   three stick offsets, yaw correction, four measured wheel speeds
// drive    source four clamped wheel drive commands, one request per tick
// cfg      sink   register index and write data, always ready
//
// Each tick passes through the shared 17-step restoring divider six times, which
// sets how long it takes from acceptance to a valid drive request; the next tick
// can be accepted once that drive request is valid.
// Reset loads the configuration defaults, clears the wheel error state and sets
// the first-tick flag; nothing else needs a clearing pass.
// A finished drive request waits in its output register; the next tick is taken
// and worked on meanwhile, and only its final publish step stalls on that register.

// Top level of the mecanum mixer with four wheel speed PID loops.
//
// The controller walks each tick through a fixed sequence. The rotate stick is
// divided by its scale, forced to zero inside the deadband, and the scaled yaw
// correction is added to it. Then, for each wheel in turn, the mixed target is
// saturated, the speed error and the saturating error sum are formed, the
// proportional and derivative products are taken while the divider scales the
// error sum, and the three terms are added, saturated and clamped at the limit.
// The derivative term is left out on the first tick after reset.
module mecanum_wheel_speed_pid_core (
	input logic          clk,
	input logic          arst_n,
	mwsp_tick_if.sink    tick,
	mwsp_drive_if.source drive,
	mwsp_cfg_if.sink     cfg
);

	mwsp_pkg::ctl_cmd_t    cmd;
	mwsp_pkg::dp_status_t  status;
	mwsp_pkg::tick_item_t  item_in;
	mwsp_pkg::drive_item_t item_out;

	// Configuration writes are taken in any cycle and land in their register at the next clock edge.
	assign cfg.ready = 1'b1;

	assign item_in.strafe_stick   = tick.strafe_stick;
	assign item_in.forward_stick  = tick.forward_stick;
	assign item_in.rotate_stick   = tick.rotate_stick;
	assign item_in.yaw_correction = tick.yaw_correction;
	assign item_in.speed_front_a  = tick.speed_front_a;
	assign item_in.speed_front_b  = tick.speed_front_b;
	assign item_in.speed_rear_a   = tick.speed_rear_a;
	assign item_in.speed_rear_b   = tick.speed_rear_b;

	assign drive.drive_front_a = item_out.drive_front_a;
	assign drive.drive_front_b = item_out.drive_front_b;
	assign drive.drive_rear_a  = item_out.drive_rear_a;
	assign drive.drive_rear_b  = item_out.drive_rear_b;

	mwsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (drive.valid),
		.out_ready (drive.ready),
		.cmd       (cmd),
		.status    (status)
	);

	mwsp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item_in   (item_in),
		.item_out  (item_out),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data)
	);

endmodule

### dv/mecanum_wheel_speed_pid_core_tb.sv
`timescale 1ns / 1ps

// Testbench for the mecanum mixer with four wheel speed PID loops.
//
// Control ticks are sent on the tick channel in random bursts. Each accepted
// tick is run through a local model of the mixer and the four wheel loops.
// The model keeps its own error sums, last errors and first-tick flag. The
// drive requests it predicts wait in a queue. Every drive request that the
// block hands out is checked field by field against the oldest prediction.
// Register writes happen only while nothing is in flight.
module mecanum_wheel_speed_pid_core_tb;
	import mwsp_pkg::*;

	// Index past the last register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// Cycles from tick acceptance to a valid drive request.
	localparam int TICK_LATENCY  = 127;
	// Cycles with no accepted request of any kind before the run is declared hung.
	// This covers the block latency, the longest sender gap and the long hold-off.
	localparam int STALL_LIMIT   = 4000;
	// Length of the deliberate output hold-off that fills the block up.
	localparam int HOLD_CYCLES   = 800;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_TICKS   = 90;

	logic clk;
	logic arst_n;

	mwsp_tick_if  tick_bus();
	mwsp_drive_if drive_bus();
	mwsp_cfg_if   cfg_bus();

	mecanum_wheel_speed_pid_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.drive  (drive_bus),
		.cfg    (cfg_bus)
	);

	// Local copy of the configuration registers, starting at their reset values.
	logic [GAIN_W-1:0]  prop_gain_q   = PROP_GAIN_RST;
	logic [GAIN_W-1:0]  int_div_q     = INT_DIV_RST;
	logic [GAIN_W-1:0]  deriv_gain_q  = DERIV_GAIN_RST;
	logic [LIMIT_W-1:0] out_limit_q   = OUT_LIMIT_RST;
	logic [GAIN_W-1:0]  rot_div_q     = ROT_DIV_RST;
	logic [BAND_W-1:0]  rot_band_q    = ROT_BAND_RST;
	logic [GAIN_W-1:0]  yaw_div_q     = YAW_DIV_RST;

	// Local copy of the wheel loop state.
	longint wheel_err_sum [WHEEL_COUNT];
	longint wheel_last_err[WHEEL_COUNT];
	bit     first_tick_due = 1'b1;

	// Drive requests that the block still owes us, oldest first.
	drive_item_t pending_drives[$];

	int fail_count     = 0;
	int ticks_sent     = 0;
	int drives_checked = 0;
	int reg_writes     = 0;

	// Sender pacing.
	bit sender_steady = 1'b0;
	int burst_left    = 0;

	// Receiver pacing. The test sets hold_ask; the receiver turns it into a
	// countdown of its own.
	bit hold_ask   = 1'b0;
	int hold_left  = 0;
	int stall_mode = 0;
	int mode_left  = 0;
	int idle_count = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Model of the block
	// ---------------------------------------------------------------------

	function automatic longint clip16(input longint v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	// A divisor register holding zero behaves as a divisor of one.
	function automatic longint divisor_of(input logic [GAIN_W-1:0] d);
		return (d == '0) ? 64'sd1 : longint'(d);
	endfunction

	// Registers keep only as many data bits as they are wide.
	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
	                                        input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_PROP_GAIN:  prop_gain_q  = value[GAIN_W-1:0];
			REG_INT_DIV:    int_div_q    = value[GAIN_W-1:0];
			REG_DERIV_GAIN: deriv_gain_q = value[GAIN_W-1:0];
			REG_OUT_LIMIT:  out_limit_q  = value[LIMIT_W-1:0];
			REG_ROT_DIV:    rot_div_q    = value[GAIN_W-1:0];
			REG_ROT_BAND:   rot_band_q   = value[BAND_W-1:0];
			REG_YAW_DIV:    yaw_div_q    = value[GAIN_W-1:0];
			default: ;
		endcase
	endfunction

	// Works out the four drives for one tick and advances the wheel state.
	function automatic drive_item_t predict_drives(input tick_item_t t);
		longint strafe, fwd, rot, mag, err, sum, drv;
		longint target[WHEEL_COUNT];
		longint speed [WHEEL_COUNT];
		logic signed [WORD_W-1:0] drv_word[WHEEL_COUNT];
		drive_item_t d;

		strafe = $signed(t.strafe_stick);
		fwd    = $signed(t.forward_stick);
		speed[0] = $signed(t.speed_front_a);
		speed[1] = $signed(t.speed_front_b);
		speed[2] = $signed(t.speed_rear_a);
		speed[3] = $signed(t.speed_rear_b);

		// Scale the rotate stick, apply the deadband, then add the yaw term.
		rot = longint'($signed(t.rotate_stick)) / divisor_of(rot_div_q);
		mag = (rot < 0) ? -rot : rot;
		if (mag < longint'(rot_band_q)) begin
			rot = 0;
		end
		rot = rot + longint'($signed(t.yaw_correction)) / divisor_of(yaw_div_q);

		target[0] = clip16( fwd + strafe + rot);
		target[1] = clip16(-fwd + strafe + rot);
		target[2] = clip16(-fwd - strafe + rot);
		target[3] = clip16( fwd - strafe + rot);

		for (int w = 0; w < WHEEL_COUNT; w++) begin
			err = clip16(target[w] - speed[w]);
			sum = clip16(wheel_err_sum[w] + err);
			drv = longint'(prop_gain_q) * err + sum / divisor_of(int_div_q);
			if (!first_tick_due) begin
				drv = drv + longint'(deriv_gain_q) * (err - wheel_last_err[w]);
			end
			drv = clip16(drv);
			// Only the upper side is clamped; negative drives pass unchanged.
			if (drv > longint'(out_limit_q)) begin
				drv = longint'(out_limit_q);
			end
			wheel_err_sum[w]  = sum;
			wheel_last_err[w] = err;
			drv_word[w]       = drv[WORD_W-1:0];
		end
		first_tick_due = 1'b0;

		d.drive_front_a = drv_word[0];
		d.drive_front_b = drv_word[1];
		d.drive_rear_a  = drv_word[2];
		d.drive_rear_b  = drv_word[3];
		return d;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic tick_item_t make_tick(input int strafe, input int fwd, input int rot,
	                                         input int yaw, input int s0, input int s1,
	                                         input int s2, input int s3);
		tick_item_t t;
		t.strafe_stick   = STICK_W'(strafe);
		t.forward_stick  = STICK_W'(fwd);
		t.rotate_stick   = STICK_W'(rot);
		t.yaw_correction = WORD_W'(yaw);
		t.speed_front_a  = WORD_W'(s0);
		t.speed_front_b  = WORD_W'(s1);
		t.speed_rear_a   = WORD_W'(s2);
		t.speed_rear_b   = WORD_W'(s3);
		return t;
	endfunction

	// Most ticks look like a chassis that roughly tracks its targets, so the
	// integrators stay off the rails. The rest use the full range of every field.
	function automatic tick_item_t random_tick();
		int strafe, fwd, rot, yaw, base;
		int spd[WHEEL_COUNT];

		strafe = int'($urandom_range(0, 2047)) - 1024;
		fwd    = int'($urandom_range(0, 2047)) - 1024;
		rot    = int'($urandom_range(0, 2047)) - 1024;
		if ($urandom_range(0, 9) < 7) begin
			yaw = int'($urandom_range(0, 4000)) - 2000;
			for (int w = 0; w < WHEEL_COUNT; w++) begin
				case (w)
					0: base =  fwd + strafe;
					1: base = -fwd + strafe;
					2: base = -fwd - strafe;
					default: base = fwd - strafe;
				endcase
				spd[w] = base + int'($urandom_range(0, 600)) - 300;
			end
		end else begin
			yaw = int'($urandom_range(0, 65535)) - 32768;
			for (int w = 0; w < WHEEL_COUNT; w++) begin
				spd[w] = int'($urandom_range(0, 65535)) - 32768;
			end
		end
		return make_tick(strafe, fwd, rot, yaw, spd[0], spd[1], spd[2], spd[3]);
	endfunction

	// Offers one tick until the block takes it, predicts its drives, and then
	// decides whether the sender pauses before the next one.
	task automatic send_tick(input tick_item_t t);
		int gap;

		@(negedge clk);
		tick_bus.strafe_stick   = t.strafe_stick;
		tick_bus.forward_stick  = t.forward_stick;
		tick_bus.rotate_stick   = t.rotate_stick;
		tick_bus.yaw_correction = t.yaw_correction;
		tick_bus.speed_front_a  = t.speed_front_a;
		tick_bus.speed_front_b  = t.speed_front_b;
		tick_bus.speed_rear_a   = t.speed_rear_a;
		tick_bus.speed_rear_b   = t.speed_rear_b;
		tick_bus.valid          = 1'b1;
		do @(posedge clk); while (!tick_bus.ready);
		pending_drives.push_back(predict_drives(t));
		ticks_sent++;

		gap = 0;
		if (!sender_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
			end else if ($urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 3);
			end
			burst_left--;
		end
		if (gap > 0) begin
			@(negedge clk);
			tick_bus.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drops valid after the last tick of a sequence and waits for every
	// predicted drive to come back. Each tick yields a drive, so the block is
	// idle once the queue is empty.
	task automatic drain_ticks();
		if (tick_bus.valid) begin
			@(negedge clk);
			tick_bus.valid = 1'b0;
		end
		while (pending_drives.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.index = idx;
		cfg_bus.data  = value;
		cfg_bus.valid = 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		apply_reg_write(idx, value);
		reg_writes++;
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Picks a register value: often an extreme, sometimes a value with bits
	// above the register width so that masking is exercised.
	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int width);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return CFG_DATA_W'((1 << width) - 1);
			2: return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
			3: return CFG_DATA_W'($urandom_range(1, 16));
			default: return CFG_DATA_W'($urandom_range(0, (1 << width) - 1));
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Runs with the reset configuration: the first tick without a derivative,
	// the rotate deadband edges, saturation of targets, errors, sums and drives.
	task automatic test_reset_defaults();
		// First tick after reset: no derivative term on any wheel.
		send_tick(make_tick(100, 200, 300, 1500, 10, -20, 30, -40));
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
		// Rotate 45 scales to 9, inside the deadband of 10, and is dropped.
		send_tick(make_tick(0, 0, 45, 0, 0, 0, 0, 0));
		// Rotate 50 scales to exactly the deadband and is kept; also negative.
		send_tick(make_tick(0, 0, 50, 0, 0, 0, 0, 0));
		send_tick(make_tick(0, 0, -50, 0, 0, 0, 0, 0));
		send_tick(make_tick(0, 0, -49, 30, 0, 0, 0, 0));
		// Largest positive sticks against the most negative speeds: the error
		// saturates and the drive is clamped at the limit.
		send_tick(make_tick(1023, 1023, 1023, 32767, -32768, -32768, -32768, -32768));
		send_tick(make_tick(1023, 1023, 1023, 32767, -32768, -32768, -32768, -32768));
		// Most negative sticks against the largest speeds: negative saturation,
		// and a large derivative from the sign swing.
		send_tick(make_tick(-1024, -1024, -1024, -32768, 32767, 32767, 32767, 32767));
		send_tick(make_tick(-1024, -1024, -1024, -32768, 32767, 32767, 32767, 32767));
		send_tick(make_tick(-1024, -1024, -1024, -32768, 32767, 32767, 32767, 32767));
		drain_ticks();
	endtask

	// Drives every register to both ends of its range, plus a write to the
	// unused index and writes whose data has bits above the register width.
	task automatic test_register_extremes();
		write_reg(REG_PROP_GAIN, 15'd255);
		write_reg(REG_INT_DIV, 15'd0);
		write_reg(REG_DERIV_GAIN, 15'd255);
		write_reg(REG_OUT_LIMIT, 15'd0);
		write_reg(REG_ROT_DIV, 15'd0);
		write_reg(REG_ROT_BAND, 15'd1023);
		write_reg(REG_YAW_DIV, 15'd0);
		write_reg(REG_SPARE, 15'h7fff);
		// With unit divisors the rotate and yaw terms drive three of the four targets to saturation.
		send_tick(make_tick(1023, 1023, 1023, 32767, 0, 0, 0, 0));
		send_tick(make_tick(-1024, -1024, -1024, -32768, 0, 0, 0, 0));
		// Rotate 1022 sits inside the widest deadband; 1023 does not.
		send_tick(make_tick(0, 0, 1022, 0, 100, -100, 100, -100));
		send_tick(make_tick(0, 0, 1023, 0, -5, 5, -5, 5));
		drain_ticks();

		// Upper bits beyond the register width must be dropped: the gains and the deadband become 0.
		write_reg(REG_PROP_GAIN, 15'h7f00);
		write_reg(REG_INT_DIV, 15'd255);
		write_reg(REG_DERIV_GAIN, 15'h7e00);
		write_reg(REG_OUT_LIMIT, 15'd32767);
		write_reg(REG_ROT_DIV, 15'd255);
		write_reg(REG_ROT_BAND, 15'h7c00);
		write_reg(REG_YAW_DIV, 15'd255);
		send_tick(make_tick(1023, -1024, 1023, 32767, -32768, 32767, -32768, 32767));
		send_tick(make_tick(-1024, 1023, -1024, -32768, 32767, -32768, 32767, -32768));
		send_tick(make_tick(5, -7, 254, -254, 1, -1, 2, -2));
		drain_ticks();
	endtask

	// Several phases, each with a fresh random configuration, followed by a
	// run of random ticks with random sender and receiver pacing.
	task automatic test_random_traffic();
		cfg_reg_t r;
		int width;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			r = r.first();
			repeat (r.num()) begin
				case (r)
					REG_OUT_LIMIT: width = LIMIT_W;
					REG_ROT_BAND:  width = BAND_W;
					default:       width = GAIN_W;
				endcase
				write_reg(r, pick_reg_value(width));
				r = r.next();
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
			end
			repeat (PHASE_TICKS) send_tick(random_tick());
			drain_ticks();
		end
	endtask

	// Holds the drive channel off for a long stretch while ticks keep coming
	// back to back, so the block fills up and must stall its input.
	task automatic test_output_backpressure();
		sender_steady = 1'b1;
		hold_ask      = 1'b1;
		repeat (30) send_tick(random_tick());
		sender_steady = 1'b0;
		drain_ticks();
	endtask

	// ---------------------------------------------------------------------
	// Receiver pacing, checking and watchdog
	// ---------------------------------------------------------------------

	// The drive channel moves between steady readiness, random stalls and a
	// fixed duty pattern, or holds off completely when asked to.
	always @(negedge clk) begin
		if (hold_ask) begin
			hold_left = HOLD_CYCLES;
			hold_ask  = 1'b0;
		end
		if (hold_left > 0) begin
			drive_bus.ready = 1'b0;
			hold_left--;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(50, 600);
			end
			mode_left--;
			case (stall_mode)
				0: drive_bus.ready = 1'b1;
				1: drive_bus.ready = ($urandom_range(0, 3) != 0);
				2: drive_bus.ready = ((mode_left % 7) < 4);
				default: drive_bus.ready = $urandom_range(0, 1);
			endcase
		end
	end

	function automatic void compare_drive(input string field,
	                                      input logic signed [WORD_W-1:0] expected,
	                                      input logic signed [WORD_W-1:0] actual);
		if (actual !== expected) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		drive_item_t want;
		if (arst_n && drive_bus.valid && drive_bus.ready) begin
			if (pending_drives.size() == 0) begin
				$display("%0t: drive request with nothing expected (%0d %0d %0d %0d)", $time,
				         drive_bus.drive_front_a, drive_bus.drive_front_b,
				         drive_bus.drive_rear_a, drive_bus.drive_rear_b);
				fail_count++;
			end else begin
				want = pending_drives.pop_front();
				compare_drive("drive_front_a", want.drive_front_a, drive_bus.drive_front_a);
				compare_drive("drive_front_b", want.drive_front_b, drive_bus.drive_front_b);
				compare_drive("drive_rear_a", want.drive_rear_a, drive_bus.drive_rear_a);
				compare_drive("drive_rear_b", want.drive_rear_b, drive_bus.drive_rear_b);
				drives_checked++;
			end
		end
	end

	// Any accepted request on any channel counts as progress.
	always @(posedge clk) begin
		if ((tick_bus.valid && tick_bus.ready) || (drive_bus.valid && drive_bus.ready) ||
		    (cfg_bus.valid && cfg_bus.ready)) begin
			idle_count = 0;
		end else begin
			idle_count++;
		end
		if (idle_count >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d drives still owed", $time,
			         STALL_LIMIT, pending_drives.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			wheel_err_sum[w]  = 0;
			wheel_last_err[w] = 0;
		end
		arst_n                  = 1'b0;
		tick_bus.valid          = 1'b0;
		tick_bus.strafe_stick   = '0;
		tick_bus.forward_stick  = '0;
		tick_bus.rotate_stick   = '0;
		tick_bus.yaw_correction = '0;
		tick_bus.speed_front_a  = '0;
		tick_bus.speed_front_b  = '0;
		tick_bus.speed_rear_a   = '0;
		tick_bus.speed_rear_b   = '0;
		drive_bus.ready         = 1'b0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.index           = '0;
		cfg_bus.data            = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();

		// Give a stray extra drive request time to show up.
		repeat (2 * TICK_LATENCY) @(posedge clk);

		$display("Sent %0d ticks and checked %0d drive requests across %0d register writes,",
		         ticks_sent, drives_checked, reg_writes);
		$display("including register extremes, deadband edges and a long output hold-off.");
		if (fail_count == 0 && pending_drives.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
